### rtl/adpcm_sb_pkg.sv
// adpcm_sb_pkg: shared types and constants for the adpcm sample buffer block
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package adpcm_sb_pkg;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_FILL,
    CTL_REPLY
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_buf;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic buf_read;
  } dp_status_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [7:0] REG_LATCH_LO = 8'h08;
  localparam logic [7:0] REG_LATCH_HI = 8'h09;
  localparam logic [7:0] REG_DATA     = 8'h0A;
  localparam logic [7:0] REG_CTRL_ONE = 8'h0B;
  localparam logic [7:0] REG_VERSION  = 8'h0C;
  localparam logic [7:0] REG_CTRL_TWO = 8'h0D;
  localparam logic [7:0] REG_ID_0     = 8'hC1;
  localparam logic [7:0] REG_ID_1     = 8'hC2;
  localparam logic [7:0] REG_ID_2     = 8'hC3;

  localparam logic [7:0] VAL_VERSION = 8'h01;
  localparam logic [7:0] VAL_ID_0    = 8'hAA;
  localparam logic [7:0] VAL_ID_1    = 8'h55;
  localparam logic [7:0] VAL_ID_2    = 8'h03;

  localparam int unsigned CTL2_WPTR_BIT = 0;
  localparam int unsigned CTL2_RPTR_BIT = 3;
  localparam int unsigned CTL2_LEN_BIT  = 4;
  localparam logic [7:0]  CTL2_STORE_MASK = 8'hDF;

endpackage

`default_nettype wire

### rtl/adpcm_sb_ram.sv
// adpcm_sb_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module adpcm_sb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/adpcm_sb_ctrl.sv
// adpcm_sb_ctrl: sequencing of one bus access (capture, execute, buffer fill, reply)
// depends on adpcm_sb_pkg
`default_nettype none

module adpcm_sb_ctrl import adpcm_sb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  ctl_state_e state_q, state_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    busy_o           = 1'b1;
    done_o           = 1'b0;
    accept           = 1'b0;
    case (state_q)
      CTL_IDLE: begin
        busy_o = 1'b0;
        accept = start_i;
      end
      CTL_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = status_i.buf_read ? CTL_FILL : CTL_REPLY;
      end
      CTL_FILL: begin
        cmd_o.load_buf = 1'b1;
        state_d        = CTL_REPLY;
      end
      CTL_REPLY: begin
        busy_o  = 1'b0;
        done_o  = 1'b1;
        accept  = start_i;
        state_d = CTL_IDLE;
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
    if (accept) begin
      cmd_o.capture = 1'b1;
      state_d       = CTL_EXEC;
    end
  end

endmodule

`default_nettype wire

### rtl/adpcm_sb_dp.sv
// adpcm_sb_dp: register file, pointers, read buffer and sample memory port
// depends on adpcm_sb_pkg and adpcm_sb_ram
`default_nettype none

module adpcm_sb_dp import adpcm_sb_pkg::*; #(
  parameter int unsigned AddrBits = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_cmd_t    cmd_i,
  input  wire logic       operation_i,
  input  wire logic [7:0] address_i,
  input  wire logic [7:0] write_data_i,
  output dp_status_t      status_o,
  output logic      [7:0] read_data_o
);

  logic                op_q;
  logic [7:0]          addr_q;
  logic [7:0]          wdata_q;
  logic [15:0]         latch_q, latch_d;
  logic [AddrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [7:0]          rd_buf_q, rd_buf_d;
  logic [15:0]         length_q, length_d;
  logic [7:0]          ctrl1_q, ctrl1_d;
  logic [7:0]          ctrl2_q, ctrl2_d;
  logic [7:0]          rdata_q, rdata_d;
  logic                is_data;
  logic                mem_we;
  logic                mem_re;
  logic [AddrBits-1:0] mem_addr;
  logic [7:0]          mem_rdata;
  logic [7:0]          reg_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
  end

  assign is_data           = (addr_q == REG_DATA);
  assign status_o.buf_read = is_data && (op_q == OP_READ);
  assign mem_we            = cmd_i.execute && is_data && (op_q == OP_WRITE);
  assign mem_re            = cmd_i.execute && status_o.buf_read;
  assign mem_addr          = (op_q == OP_WRITE) ? wr_ptr_q : rd_ptr_q;

  adpcm_sb_ram #(
    .Width (8),
    .Depth (2 ** AddrBits)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (wdata_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    case (addr_q)
      REG_DATA:     reg_rdata = rd_buf_q;
      REG_CTRL_ONE: reg_rdata = ctrl1_q;
      REG_VERSION:  reg_rdata = VAL_VERSION;
      REG_CTRL_TWO: reg_rdata = ctrl2_q;
      REG_ID_0:     reg_rdata = VAL_ID_0;
      REG_ID_1:     reg_rdata = VAL_ID_1;
      REG_ID_2:     reg_rdata = VAL_ID_2;
      default:      reg_rdata = 8'h00;
    endcase
  end

  always_comb begin
    latch_d  = latch_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    rd_buf_d = rd_buf_q;
    length_d = length_q;
    ctrl1_d  = ctrl1_q;
    ctrl2_d  = ctrl2_q;
    rdata_d  = rdata_q;
    if (cmd_i.execute) begin
      if (op_q == OP_WRITE) begin
        rdata_d = 8'h00;
        case (addr_q)
          REG_LATCH_LO: latch_d = {latch_q[15:8], wdata_q};
          REG_LATCH_HI: latch_d = {wdata_q, latch_q[7:0]};
          REG_DATA: begin
            rd_buf_d = wdata_q;
            wr_ptr_d = wr_ptr_q + AddrBits'(1);
          end
          REG_CTRL_ONE: ctrl1_d = wdata_q;
          REG_CTRL_TWO: begin
            if (wdata_q[CTL2_WPTR_BIT]) begin
              wr_ptr_d = AddrBits'(latch_q);
            end
            if (ctrl2_q[CTL2_RPTR_BIT] && !wdata_q[CTL2_RPTR_BIT]) begin
              rd_ptr_d = AddrBits'(latch_q);
            end
            if (wdata_q[CTL2_LEN_BIT]) begin
              length_d = latch_q;
            end
            ctrl2_d = wdata_q & CTL2_STORE_MASK;
          end
          default: ;
        endcase
      end else begin
        rdata_d = reg_rdata;
        if (is_data) begin
          rd_ptr_d = rd_ptr_q + AddrBits'(1);
        end
      end
    end
    if (cmd_i.load_buf) begin
      rd_buf_d = mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      rd_buf_q <= '0;
      length_q <= '0;
      ctrl1_q  <= '0;
      ctrl2_q  <= '0;
      rdata_q  <= '0;
    end else begin
      latch_q  <= latch_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      rd_buf_q <= rd_buf_d;
      length_q <= length_d;
      ctrl1_q  <= ctrl1_d;
      ctrl2_q  <= ctrl2_d;
      rdata_q  <= rdata_d;
    end
  end

  assign read_data_o = rdata_q;

endmodule

`default_nettype wire

### rtl/adpcm_sample_buffer_registers.sv
// sequence: an accepted access is captured, executed and then strobed in the reply state;
// a read of the data port adds a fill state (the sample ram read is registered and
// refills the read buffer in that state); no access is taken while busy, and a new
// access is taken in the strobe cycle; the receiver cannot stall
// reset: asynchronous, clears pointers, latch, buffer and control registers; the
// sample ram holds no reset state
`default_nettype none

module adpcm_sample_buffer_registers import adpcm_sb_pkg::*; #(
  parameter int unsigned BufferAddrBits = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       operation_i,
  input  wire logic [7:0] address_i,
  input  wire logic [7:0] write_data_i,
  output logic            done_o,
  output logic      [7:0] read_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  adpcm_sb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  adpcm_sb_dp #(
    .AddrBits (BufferAddrBits)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .status_o     (status),
    .read_data_o  (read_data_o)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_done_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("strobe while not ready for the next transfer");

  a_done_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("strobe without a transfer in progress");
`endif

endmodule

`default_nettype wire
